FILE: design/positional_insert_delete_list_macros.svh
`ifndef POSITIONAL_INSERT_DELETE_LIST_MACROS_SVH
`define POSITIONAL_INSERT_DELETE_LIST_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PIDL_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define PIDL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/pidl_pkg.sv
package pidl_pkg;

   // List geometry
   localparam int Capacity      = 16;
   localparam int CntWidth      = $clog2(Capacity + 1);
   localparam int IdxWidth      = $clog2(Capacity);
   localparam int PosWidth      = 8;
   localparam int DataWidth     = 32;
   localparam int CountOutWidth = 7;

   typedef enum logic [1:0] {
      OP_INSERT  = 2'd0,
      OP_VIEW    = 2'd1,
      OP_DEL_POS = 2'd2,
      OP_DEL_VAL = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE = 2'd0,
      ST_NULL = 2'd1,
      ST_FULL = 2'd2,
      ST_BAD  = 2'd3
   } status_type;

   typedef struct packed {
      op_type                      operation;
      logic signed [PosWidth-1:0]  position;
      logic [DataWidth-1:0]        value;
   } req_type;

   typedef struct packed {
      status_type                  status;
      logic [DataWidth-1:0]        read_value;
      logic [CountOutWidth-1:0]    count;
   } rsp_type;

   // Command broadcast to every cell of the row
   typedef struct packed {
      logic                        ins_en;
      logic                        del_pos_en;
      logic                        del_val_en;
      logic [PosWidth-1:0]         target;
      logic [DataWidth-1:0]        value;
      logic [CntWidth-1:0]         count;
   } cell_cmd_type;

endpackage

FILE: design/positional_insert_delete_list.sv
// Ordered list of up to Capacity 32-bit words held in a row of cells, one word
// per cell. Every operation (insert, view, delete at position, delete first
// equal word) is handled by all cells at once: each cell compares its position and word
// against the broadcast item and loads from its left or right neighbor, and a
// one-bit hit chain through the row marks the first equal word. The result is
// registered and shows up the cycle after the item is accepted; with rsp_ready
// held high the block takes one item every cycle. A zero word is never stored.
// No clearing pass is needed after reset: only entries below the count are
// ever read.
`include "positional_insert_delete_list_macros.svh"

module positional_insert_delete_list import pidl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   logic [DataWidth-1:0] cell_data [Capacity];
   logic [DataWidth-1:0] cell_view [Capacity];
   logic                 hit_chain [Capacity+1];
   logic [DataWidth-1:0] view_or;

   logic [CntWidth-1:0]  count_ff;
   logic [CntWidth-1:0]  count_in;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;
   rsp_type              rsp_in;
   status_type           status_in;
   cell_cmd_type         cmd;

   logic                 accept;
   logic [PosWidth-1:0]  pos_u;
   logic [PosWidth-1:0]  count_wide;
   logic [PosWidth-1:0]  ins_target;
   logic                 pos_ok;
   logic                 val_null;
   logic                 full;
   logic                 found;
   logic                 ins_ok;
   logic                 del_pos_ok;
   logic                 del_val_ok;
   logic [PosWidth-1:0]  target;
   logic [DataWidth-1:0] read_in;

   // Handshake: output register frees as it drains
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Position checks
   assign pos_u      = req_payload.position;
   assign count_wide = PosWidth'(count_ff);
   assign pos_ok     = !pos_u[PosWidth-1] && (pos_u < count_wide);
   assign ins_target = (pos_u[PosWidth-1] || (pos_u > count_wide)) ? count_wide : pos_u;
   assign val_null   = (req_payload.value == '0);
   assign full       = (count_ff == CntWidth'(Capacity));
   assign found      = hit_chain[Capacity];

   // Row enables and target, from the item and the current count
   always_comb begin
      ins_ok     = 1'b0;
      del_pos_ok = 1'b0;
      del_val_ok = 1'b0;
      target     = pos_u;
      unique case (req_payload.operation)
         OP_INSERT: begin
            ins_ok = !val_null && !full;
            target = ins_target;
         end
         OP_DEL_POS: begin
            del_pos_ok = pos_ok;
         end
         OP_DEL_VAL: begin
            del_val_ok = !val_null;
         end
         default: begin
            ins_ok = 1'b0;
         end
      endcase
   end

   // Status, count and read word
   always_comb begin
      status_in = ST_DONE;
      count_in  = count_ff;
      read_in   = '0;
      unique case (req_payload.operation)
         OP_INSERT: begin
            if (val_null) begin
               status_in = ST_NULL;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               count_in = CntWidth'(count_ff + 1'b1);
            end
         end
         OP_VIEW: begin
            if (pos_ok) begin
               read_in = view_or;
            end else begin
               status_in = ST_BAD;
            end
         end
         OP_DEL_POS: begin
            if (pos_ok) begin
               count_in = CntWidth'(count_ff - 1'b1);
            end else begin
               status_in = ST_BAD;
            end
         end
         OP_DEL_VAL: begin
            if (val_null) begin
               status_in = ST_NULL;
            end else if (found) begin
               count_in = CntWidth'(count_ff - 1'b1);
            end else begin
               status_in = ST_BAD;
            end
         end
         default: begin
            status_in = ST_BAD;
         end
      endcase
   end

   // Command to the cell row, only on an accepted item
   always_comb begin
      cmd.ins_en     = accept && ins_ok;
      cmd.del_pos_en = accept && del_pos_ok;
      cmd.del_val_en = accept && del_val_ok;
      cmd.target     = target;
      cmd.value      = req_payload.value;
      cmd.count      = count_ff;
   end

   // Cell row
   assign hit_chain[0] = 1'b0;

   for (genvar i = 0; i < Capacity; i++) begin : g_cell
      logic [DataWidth-1:0] left_data;
      logic [DataWidth-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = req_payload.value;
      end else begin : g_mid_left
         assign left_data = cell_data[i-1];
      end

      if (i == Capacity - 1) begin : g_last
         assign right_data = cell_data[i];
      end else begin : g_mid_right
         assign right_data = cell_data[i+1];
      end

      pidl_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .idx        (IdxWidth'(i)),
         .left_data  (left_data),
         .right_data (right_data),
         .hit_in     (hit_chain[i]),
         .data_out   (cell_data[i]),
         .hit_out    (hit_chain[i+1]),
         .view_data  (cell_view[i])
      );
   end

   // View read: at most one cell drives a nonzero word
   always_comb begin
      view_or = '0;
      for (int k = 0; k < Capacity; k++) begin
         view_or = view_or | cell_view[k];
      end
   end

   // Result item
   always_comb begin
      rsp_in.status     = status_in;
      rsp_in.read_value = read_in;
      rsp_in.count      = CountOutWidth'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `PIDL_ASSERT_SAME(a_count_cap, clock, reset, 1'b1,
      count_ff <= CntWidth'(Capacity), "count beyond capacity")
   `PIDL_ASSERT_NEXT(a_reject_keeps, clock, reset, accept && status_in != ST_DONE,
      count_ff == $past(count_ff), "rejected item changed count")
   `PIDL_ASSERT_NEXT(a_insert_grows, clock, reset,
      accept && req_payload.operation == OP_INSERT && status_in == ST_DONE,
      count_ff == CntWidth'($past(count_ff) + 1'b1), "insert did not grow count")
   `PIDL_ASSERT_NEXT(a_delete_shrinks, clock, reset,
      accept && (req_payload.operation == OP_DEL_POS ||
                 req_payload.operation == OP_DEL_VAL) && status_in == ST_DONE,
      count_ff == CntWidth'($past(count_ff) - 1'b1), "delete did not shrink count")
   `PIDL_ASSERT_SAME(a_read_only_done, clock, reset,
      rsp_valid_ff && rsp_ff.read_value != '0,
      rsp_ff.status == ST_DONE, "read word on failed item")

endmodule

FILE: design/pidl_cell.sv
module pidl_cell import pidl_pkg::*; (
   input  logic                 clock,
   input  cell_cmd_type         cmd,
   input  logic [IdxWidth-1:0]  idx,
   input  logic [DataWidth-1:0] left_data,
   input  logic [DataWidth-1:0] right_data,
   input  logic                 hit_in,
   output logic [DataWidth-1:0] data_out,
   output logic                 hit_out,
   output logic [DataWidth-1:0] view_data
);

   logic [DataWidth-1:0] data_ff;
   logic [DataWidth-1:0] data_in;
   logic [PosWidth-1:0]  idx_wide;
   logic                 at_target;
   logic                 past_target;
   logic                 in_list;
   logic                 match;

   // Position of this cell against the command
   assign idx_wide    = PosWidth'(idx);
   assign at_target   = (idx_wide == cmd.target);
   assign past_target = (idx_wide > cmd.target);
   assign in_list     = (CntWidth'(idx) < cmd.count);

   // Delete point: this cell or any cell to the left of it
   assign match   = (cmd.del_pos_en && at_target) ||
                    (cmd.del_val_en && in_list && (data_ff == cmd.value));
   assign hit_out = hit_in || match;

   // Insert shifts up from the left, delete pulls down from the right
   always_comb begin
      data_in = data_ff;
      if (cmd.ins_en) begin
         if (at_target) begin
            data_in = cmd.value;
         end else if (past_target) begin
            data_in = left_data;
         end
      end else if (hit_out) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out  = data_ff;
   assign view_data = at_target ? data_ff : '0;

endmodule
